// File: hw/rtl/sahtok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sahtok_pkg
// Shared types, keyword tables and event codes of the security agreement
// header tokenizer.
// ----------------------------------------------------------------------------
package sahtok_pkg;

  // event kinds
  localparam logic [1:0] EV_MECH    = 2'd0;
  localparam logic [1:0] EV_PARAM   = 2'd1;
  localparam logic [1:0] EV_INVALID = 2'd2;
  localparam logic [1:0] EV_END     = 2'd3;

  // mechanism codes
  localparam logic [2:0] MECH_3GPP   = 3'd0;
  localparam logic [2:0] MECH_IKEMAN = 3'd3;
  localparam logic [2:0] MECH_OTHER  = 3'd4;

  // keyword indexes
  localparam int KW_IPSEC_MAN = 4;
  localparam int KW_Q         = 5;
  localparam int KW_ALG       = 6;
  localparam int KW_SPI_C     = 9;
  localparam int KW_SPI_S     = 10;
  localparam int KW_PORT_C    = 11;
  localparam int KW_PORT_S    = 12;
  localparam int KW_D_ALG     = 13;
  localparam int KW_D_VER     = 15;
  localparam logic [4:0] NO_KW = 5'd16;

  // param id of a keyword is its index minus this
  localparam int PID_OFFSET = 4;
  localparam logic [3:0] PID_EXTRA = 4'd0;
  localparam logic [3:0] PID_Q     = 4'd1;

  localparam int QDEPTH = 8;
  localparam int MAX_EVENTS = 3;

  // keyword text, first character in the highest used byte
  localparam logic [79:0] KW_TEXT [16] = '{
    "ipsec-3gpp", "tls", "digest", "ipsec-ike", "ipsec-man",
    "q", "alg", "mod", "ealg", "spi-c", "spi-s", "port-c", "port-s",
    "d-alg", "d-qop", "d-ver"
  };
  localparam logic [3:0] KW_LEN [16] = '{
    4'd10, 4'd3, 4'd6, 4'd9, 4'd9, 4'd1, 4'd3, 4'd3,
    4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd5, 4'd5, 4'd5
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  entry;
    logic [2:0]  mech;
    logic [3:0]  pid;
    logic [9:0]  ts;
    logic [10:0] tl;
    logic [9:0]  vs;
    logic [10:0] vl;
    logic [31:0] num;
    logic        last;
  } event_t;

  // events caused by one byte
  typedef struct packed {
    logic [1:0]           cnt;
    event_t [MAX_EVENTS-1:0] ev;
  } push_t;

  // character i of keyword k equals b
  function automatic logic kw_char_ok(int k, logic [3:0] i, logic [7:0] b);
    int   sh;
    logic r;
    r = 1'b0;
    if (i < KW_LEN[k]) begin
      sh = (int'(KW_LEN[k]) - 1 - int'(i)) * 8;
      r = (KW_TEXT[k][sh +: 8] == b);
    end
    return r;
  endfunction

  function automatic event_t mk_ev(logic [1:0] kind, logic [7:0] entry, logic [2:0] mech,
                                   logic [3:0] pid, logic [9:0] ts, logic [10:0] tl,
                                   logic [9:0] vs, logic [10:0] vl, logic [31:0] num);
    event_t e;
    e.kind = kind; e.entry = entry; e.mech = mech; e.pid = pid;
    e.ts = ts; e.tl = tl; e.vs = vs; e.vl = vl; e.num = num; e.last = 1'b0;
    return e;
  endfunction

endpackage

// File: hw/rtl/sahtok_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sahtok_in_if
// Byte channel of the header tokenizer.
// ----------------------------------------------------------------------------
interface sahtok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_body;
  modport source (output valid, data_byte, end_of_body, input ready);
  modport sink (input valid, data_byte, end_of_body, output ready);
endinterface

// File: hw/rtl/sahtok_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sahtok_out_if
// Event channel of the header tokenizer.
// ----------------------------------------------------------------------------
interface sahtok_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  entry_index;
  logic [2:0]  mechanism_code;
  logic [3:0]  param_id;
  logic [9:0]  token_start;
  logic [10:0] token_length;
  logic [9:0]  value_start;
  logic [10:0] value_length;
  logic [31:0] number_value;
  logic        last_result;
  modport source (output valid, event_kind, entry_index, mechanism_code, param_id,
                  token_start, token_length, value_start, value_length, number_value,
                  last_result, input ready);
  modport sink (input valid, event_kind, entry_index, mechanism_code, param_id,
                token_start, token_length, value_start, value_length, number_value,
                last_result, output ready);
endinterface

// File: hw/rtl/sahtok_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sahtok_parser
// Per-byte parse state and event generation: tokenizer phases, incremental
// keyword match, number decoding and end-of-body finishing.
// ----------------------------------------------------------------------------
module sahtok_parser #(
  parameter int MAX_BODY_BYTES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               end_of_body,
  output sahtok_pkg::push_t  push
);

  localparam int POS_W = $clog2(MAX_BODY_BYTES + 1);
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [POS_W:0]   len_t;

  typedef enum logic [3:0] {
    PH_START, PH_MECH, PH_PNAME_START, PH_PNAME, PH_PVAL_START, PH_PVAL,
    PH_PVAL_Q, PH_PVAL_END, PH_INVALID
  } phase_t;

  typedef struct packed {
    logic [32:0] acc;
    logic [3:0]  ok;     // int ok, q ok, seen, gap
    logic        lead;
    logic [1:0]  digits;
    logic [1:0]  cnt;
    logic [9:0]  frac;
  } num_t;

  localparam num_t NUM_INIT = '{acc: '0, ok: 4'b0011, lead: 1'b0, digits: '0,
                                cnt: '0, frac: '0};

  function automatic logic is_ws(logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A;
  endfunction

  // keyword flags after one more name byte
  function automatic logic [15:0] tok_cmp(logic [15:0] fl, logic [7:0] b, len_t idx,
                                          logic gap);
    logic [15:0] r;
    r = gap ? 16'h0000 : fl;
    for (int k = 0; k < 16; k++) begin
      if (idx >= len_t'(sahtok_pkg::KW_LEN[k]) || !sahtok_pkg::kw_char_ok(k, idx[3:0], b))
        r[k] = 1'b0;
    end
    return r;
  endfunction

  // lowest matching keyword in a range
  function automatic logic [4:0] tok_match(logic [15:0] fl, int first, int count, len_t len);
    logic [4:0] r;
    r = sahtok_pkg::NO_KW;
    for (int k = 15; k >= 0; k--) begin
      if (k >= first && k < first + count && fl[k] &&
          len_t'(sahtok_pkg::KW_LEN[k]) == len)
        r = 5'(k);
    end
    return r;
  endfunction

  // number decoder step
  function automatic num_t num_feed(num_t s, logic [7:0] b);
    num_t        r;
    logic        dig;
    logic [3:0]  d;
    logic [36:0] prod;
    r = s;
    dig = (b >= "0") && (b <= "9");
    d = dig ? 4'(b - "0") : 4'd0;
    prod = '0;
    if (is_ws(b)) begin
      if (r.ok[2]) r.ok[3] = 1'b1;
    end else if (r.ok[3]) begin
      r.ok[1:0] = 2'b00;
    end else begin
      r.ok[2] = 1'b1;
      if (dig) begin
        prod = ({4'b0, r.acc} << 3) + ({4'b0, r.acc} << 1) + 37'(d);
        if (prod > 37'h0_FFFF_FFFF) begin
          r.acc = 33'h1_0000_0000;
          r.ok[0] = 1'b0;
        end else begin
          r.acc = prod[32:0];
        end
      end else begin
        r.ok[0] = 1'b0;
      end
      if (r.cnt == 2'd0) begin
        if (b == "0" || b == "1") r.lead = b[0];
        else r.ok[1] = 1'b0;
      end else if (r.cnt == 2'd1) begin
        if (b != ".") r.ok[1] = 1'b0;
      end else if (!dig || (r.lead && d != 4'd0) || r.digits == 2'd3) begin
        r.ok[1] = 1'b0;
      end else begin
        r.frac = 10'(r.frac * 10 + 10'(d));
        r.digits = r.digits + 2'd1;
      end
      if (r.cnt != 2'd2) r.cnt = r.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic logic [2:0] mech_code(logic [4:0] k);
    logic [2:0] r;
    if (k == sahtok_pkg::NO_KW) r = sahtok_pkg::MECH_OTHER;
    else if (k == 5'(sahtok_pkg::KW_IPSEC_MAN)) r = sahtok_pkg::MECH_IKEMAN;
    else r = k[2:0];
    return r;
  endfunction

  function automatic sahtok_pkg::event_t inv_ev(logic [7:0] entry, logic [2:0] mech);
    return sahtok_pkg::mk_ev(sahtok_pkg::EV_INVALID, entry, mech, '0, '0, '0, '0, '0, '0);
  endfunction

  // finished parameter, or invalid when its number fails
  function automatic sahtok_pkg::event_t fin_param(logic [2:0] mech, logic [4:0] k, num_t n,
                                                   logic [7:0] entry, pos_t ns, len_t nl,
                                                   pos_t vs, len_t vl);
    logic [3:0]  pid;
    logic [31:0] num;
    logic        ok;
    logic        int_ok;
    logic [9:0]  scale;
    sahtok_pkg::event_t e;
    pid = sahtok_pkg::PID_EXTRA;
    num = '0;
    ok = 1'b1;
    int_ok = (n.ok[0] && n.ok[2]);
    case (n.digits)
      2'd1:    scale = 10'd100;
      2'd2:    scale = 10'd10;
      2'd3:    scale = 10'd1;
      default: scale = 10'd0;
    endcase
    if (k == 5'(sahtok_pkg::KW_Q)) begin
      pid = sahtok_pkg::PID_Q;
      ok = n.ok[1] && n.ok[2];
      num = (n.lead ? 32'd1000 : 32'd0) + 32'(n.frac) * 32'(scale);
    end else if (mech == sahtok_pkg::MECH_3GPP && k >= 5'(sahtok_pkg::KW_ALG) &&
                 k <= 5'(sahtok_pkg::KW_PORT_S)) begin
      pid = 4'(k - 5'(sahtok_pkg::PID_OFFSET));
      if (k == 5'(sahtok_pkg::KW_SPI_C) || k == 5'(sahtok_pkg::KW_SPI_S)) begin
        ok = int_ok;
        num = n.acc[31:0];
      end else if (k >= 5'(sahtok_pkg::KW_PORT_C)) begin
        ok = int_ok && n.acc[31:0] >= 32'd1 && n.acc[31:0] <= 32'd65535;
        num = n.acc[31:0];
      end
    end else if (mech != sahtok_pkg::MECH_3GPP && k >= 5'(sahtok_pkg::KW_D_ALG) &&
                 k <= 5'(sahtok_pkg::KW_D_VER)) begin
      pid = 4'(k - 5'(sahtok_pkg::PID_OFFSET));
    end
    if (ok)
      e = sahtok_pkg::mk_ev(sahtok_pkg::EV_PARAM, entry, mech, pid, 10'(ns), 11'(nl),
                            10'(vs), 11'(vl), num);
    else
      e = inv_ev(entry, mech);
    return e;
  endfunction

  // state registers
  phase_t      phase, phase_next;
  pos_t        pos, pos_next;
  pos_t        span_start, span_start_next;
  pos_t        last_ns, last_ns_next;
  pos_t        name_start, name_start_next;
  len_t        name_len, name_len_next;
  pos_t        val_start, val_start_next;
  len_t        val_len, val_len_next;
  logic [15:0] flags, flags_next;
  logic [2:0]  mech, mech_next;
  logic [4:0]  param_kw, param_kw_next;
  num_t        num, num_next;
  logic        esc, esc_next;
  logic [7:0]  entry, entry_next;

  logic               ws, sep, do_sep, pv, fv;
  len_t               idx, mlen;
  logic               gap;
  logic [1:0]         n;
  sahtok_pkg::event_t pe, fe;

  // next state and events of one byte
  always_comb begin
    phase_next = phase; pos_next = pos; span_start_next = span_start;
    last_ns_next = last_ns; name_start_next = name_start; name_len_next = name_len;
    val_start_next = val_start; val_len_next = val_len; flags_next = flags;
    mech_next = mech; param_kw_next = param_kw; num_next = num; esc_next = esc;
    entry_next = entry;
    pv = 1'b0; fv = 1'b0; pe = '0; fe = '0; do_sep = 1'b0; mlen = '0;
    ws = is_ws(data_byte);
    sep = (data_byte == ",") || (data_byte == ";");
    idx = len_t'(pos) - len_t'(span_start);
    gap = (pos != span_start) && (len_t'(pos) != len_t'(last_ns) + len_t'(1));
    push = '0;
    n = '0;

    if (pos < pos_t'(MAX_BODY_BYTES)) begin
      pos_next = pos + pos_t'(1);
      case (phase)
        PH_START: begin
          if (!ws) begin
            if (sep) begin
              pv = 1'b1; pe = inv_ev(entry, mech); do_sep = 1'b1;
            end else begin
              span_start_next = pos; last_ns_next = pos;
              flags_next = tok_cmp(16'hFFFF, data_byte, '0, 1'b0);
              phase_next = PH_MECH;
            end
          end
        end
        PH_MECH: begin
          if (!ws) begin
            if (sep) begin
              mlen = len_t'(last_ns) - len_t'(span_start) + len_t'(1);
              mech_next = mech_code(tok_match(flags, 0, 5, mlen));
              pv = 1'b1;
              pe = sahtok_pkg::mk_ev(sahtok_pkg::EV_MECH, entry, mech_next, '0,
                                     10'(span_start), 11'(mlen), '0, '0, '0);
              do_sep = 1'b1;
            end else begin
              flags_next = tok_cmp(flags, data_byte, idx, gap);
              last_ns_next = pos;
            end
          end
        end
        PH_PNAME_START: begin
          if (!ws && data_byte != ";") begin
            if (data_byte == ",") begin
              do_sep = 1'b1;
            end else if (data_byte == "=") begin
              pv = 1'b1; pe = inv_ev(entry, mech); phase_next = PH_INVALID;
            end else begin
              span_start_next = pos; last_ns_next = pos;
              flags_next = tok_cmp(16'hFFFF, data_byte, '0, 1'b0);
              phase_next = PH_PNAME;
            end
          end
        end
        PH_PNAME: begin
          if (!ws) begin
            if (data_byte == "=") begin
              name_start_next = span_start;
              name_len_next = len_t'(last_ns) - len_t'(span_start) + len_t'(1);
              param_kw_next = tok_match(flags, 5, 11, name_len_next);
              num_next = NUM_INIT;
              phase_next = PH_PVAL_START;
            end else if (sep) begin
              pv = 1'b1; pe = inv_ev(entry, mech); do_sep = 1'b1;
            end else begin
              flags_next = tok_cmp(flags, data_byte, idx, gap);
              last_ns_next = pos;
            end
          end
        end
        PH_PVAL_START: begin
          if (!ws) begin
            if (sep) begin
              pv = 1'b1; pe = inv_ev(entry, mech); do_sep = 1'b1;
            end else if (data_byte == "\"") begin
              val_start_next = pos + pos_t'(1); esc_next = 1'b0; phase_next = PH_PVAL_Q;
            end else begin
              val_start_next = pos; last_ns_next = pos;
              num_next = num_feed(num, data_byte); phase_next = PH_PVAL;
            end
          end
        end
        PH_PVAL: begin
          if (sep) begin
            val_len_next = len_t'(last_ns) - len_t'(val_start) + len_t'(1);
            pv = 1'b1;
            pe = fin_param(mech, param_kw, num, entry, name_start, name_len, val_start,
                           val_len_next);
            do_sep = 1'b1;
          end else begin
            if (!ws) last_ns_next = pos;
            num_next = num_feed(num, data_byte);
          end
        end
        PH_PVAL_Q: begin
          if (esc) begin
            esc_next = 1'b0; num_next = num_feed(num, data_byte);
          end else if (data_byte == "\\") begin
            esc_next = 1'b1; num_next = num_feed(num, data_byte);
          end else if (data_byte == "\"") begin
            val_len_next = len_t'(pos) - len_t'(val_start);
            if (val_len_next == '0) begin
              pv = 1'b1; pe = inv_ev(entry, mech); phase_next = PH_INVALID;
            end else begin
              phase_next = PH_PVAL_END;
            end
          end else begin
            num_next = num_feed(num, data_byte);
          end
        end
        PH_PVAL_END: begin
          if (!ws) begin
            if (sep) begin
              pv = 1'b1;
              pe = fin_param(mech, param_kw, num, entry, name_start, name_len, val_start,
                             val_len);
              do_sep = 1'b1;
            end else begin
              pv = 1'b1; pe = inv_ev(entry, mech); phase_next = PH_INVALID;
            end
          end
        end
        default: begin
          if (sep) do_sep = 1'b1;
        end
      endcase

      // separator: next entry or next parameter
      if (do_sep) begin
        if (data_byte == ",") begin
          phase_next = PH_START;
          if (entry != 8'd255) entry_next = entry + 8'd1;
          mech_next = sahtok_pkg::MECH_OTHER;
        end else begin
          phase_next = PH_PNAME_START;
        end
      end
    end

    // end of body: finish the open item, then the end mark
    if (end_of_body) begin
      case (phase_next)
        PH_MECH: begin
          mlen = len_t'(last_ns_next) - len_t'(span_start_next) + len_t'(1);
          fv = 1'b1;
          fe = sahtok_pkg::mk_ev(sahtok_pkg::EV_MECH, entry_next,
                                 mech_code(tok_match(flags_next, 0, 5, mlen)), '0,
                                 10'(span_start_next), 11'(mlen), '0, '0, '0);
        end
        PH_PNAME, PH_PVAL_START, PH_PVAL_Q: begin
          fv = 1'b1; fe = inv_ev(entry_next, mech_next);
        end
        PH_PVAL: begin
          fv = 1'b1;
          fe = fin_param(mech_next, param_kw_next, num_next, entry_next, name_start_next,
                         name_len_next, val_start_next,
                         len_t'(last_ns_next) - len_t'(val_start_next) + len_t'(1));
        end
        PH_PVAL_END: begin
          fv = 1'b1;
          fe = fin_param(mech_next, param_kw_next, num_next, entry_next, name_start_next,
                         name_len_next, val_start_next, val_len_next);
        end
        default: fv = 1'b0;
      endcase
    end

    // pack events in order
    if (pv) begin
      push.ev[n] = pe; n = n + 2'd1;
    end
    if (fv) begin
      push.ev[n] = fe; n = n + 2'd1;
    end
    if (end_of_body) begin
      push.ev[n] = sahtok_pkg::mk_ev(sahtok_pkg::EV_END, entry_next, '0, '0, '0, '0, '0,
                                     '0, '0);
      n = n + 2'd1;
    end
    if (n != 2'd0) push.ev[n - 2'd1].last = 1'b1;
    push.cnt = n;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_body)) begin
      phase <= PH_START; pos <= '0; span_start <= '0; last_ns <= '0;
      name_start <= '0; name_len <= '0; val_start <= '0; val_len <= '0;
      flags <= 16'hFFFF; mech <= sahtok_pkg::MECH_OTHER; param_kw <= sahtok_pkg::NO_KW;
      num <= '0; esc <= 1'b0; entry <= '0;
    end else if (accept) begin
      phase <= phase_next; pos <= pos_next; span_start <= span_start_next;
      last_ns <= last_ns_next; name_start <= name_start_next; name_len <= name_len_next;
      val_start <= val_start_next; val_len <= val_len_next; flags <= flags_next;
      mech <= mech_next; param_kw <= param_kw_next; num <= num_next; esc <= esc_next;
      entry <= entry_next;
    end
  end

endmodule

// File: hw/rtl/sahtok_evq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sahtok_evq
// Event queue: takes up to three events per byte, hands them out one per
// cycle while out_ready allows, through a registered output stage.
// ----------------------------------------------------------------------------
module sahtok_evq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_en,
  input  sahtok_pkg::push_t   push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output sahtok_pkg::event_t  out_ev
);

  localparam int IDX_W = $clog2(sahtok_pkg::QDEPTH);

  sahtok_pkg::event_t mem [sahtok_pkg::QDEPTH];
  logic [IDX_W-1:0] wp, rp;
  logic [IDX_W:0]   count;
  logic             pop;
  logic [1:0]       pushn;

  assign room  = (count <= (IDX_W + 1)'(sahtok_pkg::QDEPTH - sahtok_pkg::MAX_EVENTS));
  assign pop   = (count != '0) && (!out_valid || out_ready);
  assign pushn = push_en ? push.cnt : 2'd0;

  // storage writes
  always_ff @(posedge clk) begin
    for (int i = 0; i < sahtok_pkg::MAX_EVENTS; i++) begin
      if (2'(i) < pushn) mem[wp + IDX_W'(i)] <= push.ev[i];
    end
    if (pop) out_ev <= mem[rp];
  end

  // pointers and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0; out_valid <= 1'b0;
    end else begin
      wp <= wp + IDX_W'(pushn);
      if (pop) begin
        rp <= rp + IDX_W'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      count <= count + (IDX_W + 1)'(pushn) - (IDX_W + 1)'(pop);
    end
  end

endmodule

// File: hw/rtl/sec_agree_header_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_agree_header_tokenizer
// Splits a security agreement header body into mechanism and parameter
// events, one body byte per request.
// ----------------------------------------------------------------------------
// channel   dir  payload
// byte_ch   in   data_byte, end_of_body
// event_ch  out  event_kind .. number_value, last_result
//
// A byte is taken every cycle while the event queue has room for three events.
// Its events enter the queue at the accepting edge; the first reaches event_ch
// via the output register; they leave one per cycle while event_ch is ready,
// so bytes with several events lower the sustained rate to one event a cycle.
// Reset is synchronous; it clears parse state and empties the queue.
// A stalled event channel fills the queue and then holds byte_ch.ready low.
// ----------------------------------------------------------------------------
module sec_agree_header_tokenizer #(
  parameter int MAX_BODY_BYTES = 1024
) (
  input logic          clk,
  input logic          rst,
  sahtok_in_if.sink    byte_ch,
  sahtok_out_if.source event_ch
);

  logic               accept;
  logic               room;
  sahtok_pkg::push_t  push;
  sahtok_pkg::event_t ev;

  assign byte_ch.ready = room;
  assign accept        = byte_ch.valid && room;

  // byte parser
  sahtok_parser #(.MAX_BODY_BYTES(MAX_BODY_BYTES)) u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (byte_ch.data_byte),
    .end_of_body (byte_ch.end_of_body),
    .push        (push)
  );

  // event queue
  sahtok_evq u_evq (
    .clk       (clk),
    .rst       (rst),
    .push_en   (accept),
    .push      (push),
    .room      (room),
    .out_valid (event_ch.valid),
    .out_ready (event_ch.ready),
    .out_ev    (ev)
  );

  assign event_ch.event_kind     = ev.kind;
  assign event_ch.entry_index    = ev.entry;
  assign event_ch.mechanism_code = ev.mech;
  assign event_ch.param_id       = ev.pid;
  assign event_ch.token_start    = ev.ts;
  assign event_ch.token_length   = ev.tl;
  assign event_ch.value_start    = ev.vs;
  assign event_ch.value_length   = ev.vl;
  assign event_ch.number_value   = ev.num;
  assign event_ch.last_result    = ev.last;

`ifndef SYNTHESIS
  // an accepted final byte always yields at least its end event
  a_end_event: assert property (@(posedge clk) disable iff (rst)
    accept && byte_ch.end_of_body |-> push.cnt != 2'd0)
    else $error("final byte produced no events");

  // the end event closes the events of its byte
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    event_ch.valid && event_ch.event_kind == sahtok_pkg::EV_END |-> event_ch.last_result)
    else $error("end event without last mark");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !event_ch.valid)
    else $error("event offered after reset");
`endif

endmodule
